@@ sv/stpf_pkg.sv @@
// ----------------------------------------------------------------------------
// stpf_pkg
// Types and constants shared by the source text prefix packet filter.
// ----------------------------------------------------------------------------
package stpf_pkg;

    localparam int MaxEntriesDefault = 128;
    localparam int EntryCharsDefault = 24;
    localparam int TextMax           = 32;
    localparam int TextLenW          = 6;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_BLACK  = 2'd1;
    localparam logic [1:0] CMD_WHITE  = 2'd2;
    localparam logic [1:0] CMD_CHUNK  = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [7:0]  protocol;
        logic [63:0] chunk_bytes;
        logic [3:0]  chunk_count;
        logic        chunk_last;
    } t_in_item;

    typedef struct packed {
        logic       verdict;
        logic       matched;
        logic [6:0] matched_index;
    } t_out_item;

    // Source text as handed from the formatter to the matcher.
    typedef struct packed {
        logic [TextMax-1:0][7:0] chars;
        logic [TextLenW-1:0]     len;
    } t_text;

endpackage

@@ sv/stpf_fmt.sv @@
// ----------------------------------------------------------------------------
// stpf_fmt
// Builds the "a.b.c.d:port" text, one decimal digit at a time.
// ----------------------------------------------------------------------------
module stpf_fmt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_addr,
    input  logic [15:0]     i_port,
    output logic            o_done,
    output stpf_pkg::t_text o_text
);
    import stpf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIGIT = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_field, n_field;      // 0..3 octets, 4 port
    logic [16:0] r_val, n_val;
    logic [2:0]  r_nd, n_nd;            // digits collected
    logic [4:0][3:0] r_dig, n_dig;      // low digit first
    t_text       r_text, n_text;
    logic        r_done, n_done;

    // Divide by ten through a reciprocal, exact for values below 2^17.
    logic [16:0] w_q;
    logic [3:0]  w_r;
    logic [36:0] w_prod;
    assign w_prod = {20'd0, r_val} * 37'd104858;
    assign w_q    = w_prod[36:20];
    assign w_r    = 4'(r_val - 17'(w_q * 17'd10));

    always_comb begin
        logic [3:0] dsel;
        dsel    = 4'd0;
        n_state = r_state;
        n_field = r_field;
        n_val   = r_val;
        n_nd    = r_nd;
        n_dig   = r_dig;
        n_text  = r_text;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DIGIT;
                    n_field = 3'd0;
                    n_val   = {9'd0, i_addr[31:24]};
                    n_nd    = 3'd0;
                    n_text.len = '0;
                end
            end
            S_DIGIT: begin
                n_dig[r_nd] = w_r;
                n_nd = r_nd + 3'd1;
                n_val = w_q;
                if (w_q == 17'd0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Emit the most significant remaining digit.
                dsel = r_dig[r_nd - 3'd1];
                n_text.chars[r_text.len[4:0]] = CHAR_ZERO + {4'd0, dsel};
                n_text.len = r_text.len + TextLenW'(1);
                n_nd = r_nd - 3'd1;
                if (r_nd == 3'd1) begin
                    if (r_field == 3'd4) begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_text.chars[r_text.len[4:0] + 5'd1] =
                            (r_field == 3'd3) ? CHAR_COLON : CHAR_DOT;
                        n_text.len = r_text.len + TextLenW'(2);
                        n_field = r_field + 3'd1;
                        n_state = S_DIGIT;
                        unique case (r_field)
                            3'd0:    n_val = {9'd0, i_addr[23:16]};
                            3'd1:    n_val = {9'd0, i_addr[15:8]};
                            3'd2:    n_val = {9'd0, i_addr[7:0]};
                            default: n_val = {1'b0, i_port};
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_field <= n_field;
        r_val   <= n_val;
        r_nd    <= n_nd;
        r_dig   <= n_dig;
        r_text  <= n_text;
    end

    assign o_done = r_done;
    assign o_text = r_text;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_text.len <= TextLenW'(TextMax - 1)))
        else $error("text too long");
    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_nd <= 3'd4))
        else $error("digit overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("done while busy");
`endif
endmodule

@@ sv/source_text_prefix_packet_filter_top.sv @@
// ----------------------------------------------------------------------------
// source_text_prefix_packet_filter_top
// Prefix rule filter on the dotted-decimal source address and port text.
// ----------------------------------------------------------------------------
// Input items carry a command: a packet, a mode select or an entry chunk.
// Only packets yield an output transfer (verdict, matched, matched_index).
// A mode select is done at the edge that accepts it, so the next item may
// follow on the next cycle. A chunk writes one character per cycle into the
// entry memory, and o_in_stall stays high until the chunk is done.
// A packet first has its text built by the digit formatter. The matcher then
// walks the stored entries through the single text memory read port, reading
// each entry length and then its characters one by one, stopping an entry at
// its first mismatch and the walk at the first hit. The entry count and the
// entry lengths thus set how long a packet is in work. The block takes one
// item at a time; o_in_stall is high while an item is in work. The result
// sits in an output register while i_out_stall is high, and the block
// accepts the next item after it is taken. Reset selects blacklist mode and
// empties the list; the memories need no clearing.
// ----------------------------------------------------------------------------
module source_text_prefix_packet_filter_top #(
    parameter int MAX_ENTRIES = stpf_pkg::MaxEntriesDefault,
    parameter int ENTRY_CHARS = stpf_pkg::EntryCharsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stpf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stpf_pkg::t_out_item o_out_data
);
    import stpf_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(ENTRY_CHARS);
    localparam int CNW = $clog2(ENTRY_CHARS + 1);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = IW + CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHUNK = 3'd1;
    localparam logic [2:0] S_FMT   = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_HOLD  = 3'd7;

    logic [2:0]     r_state, n_state;
    logic           r_black, n_black;
    logic [ECW-1:0] r_count, n_count;
    logic [CNW-1:0] r_fill, n_fill;
    logic [CNW-1:0] r_len, n_len;       // running zero-free length
    logic           r_zero, n_zero;     // a zero char was seen
    t_in_item       r_item, n_item;
    logic [3:0]     r_ci, n_ci;
    logic [IW-1:0]  r_ei, n_ei;
    logic [CNW-1:0] r_k, n_k;
    logic [CNW-1:0] r_elen;
    logic           r_hit, n_hit;
    logic [IW-1:0]  r_hidx, n_hidx;
    logic           r_ov, n_ov;
    t_out_item      r_out, n_out;

    logic [7:0]     mem_text [MAX_ENTRIES*(1<<CW)];
    logic [CNW-1:0] mem_len  [MAX_ENTRIES];
    logic [7:0]     r_rd_char;
    logic [CNW-1:0] r_rd_len;

    logic           w_txt_we;
    logic [AW-1:0]  w_txt_wa, w_txt_ra;
    logic [7:0]     w_txt_wd;
    logic           w_len_we;

    logic           w_fmt_start, w_fmt_done;
    t_text          w_text;
    logic [15:0]    w_port;
    logic [31:0]    w_fmt_addr;

    // The formatter takes the first octet at the accepting edge, before the
    // item has reached r_item.
    assign w_fmt_addr = (r_state == S_IDLE) ? i_in_data.source_address
                                            : r_item.source_address;
    assign w_port = (r_item.protocol == PROTO_TCP || r_item.protocol == PROTO_UDP)
        ? r_item.source_port : 16'd0;

    stpf_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fmt_start),
        .i_addr  (w_fmt_addr),
        .i_port  (w_port),
        .o_done  (w_fmt_done),
        .o_text  (w_text)
    );

    logic [3:0]  w_n;
    logic [7:0]  w_ch;
    logic [CNW-1:0] w_n1;
    assign w_n  = (r_item.chunk_count > 4'd8) ? 4'd8 : r_item.chunk_count;
    assign w_ch = r_item.chunk_bytes[{r_ci[2:0], 3'b000} +: 8];
    assign w_n1 = r_rd_len - CNW'(1);

    always_comb begin
        n_state = r_state;
        n_black = r_black;
        n_count = r_count;
        n_fill  = r_fill;
        n_len   = r_len;
        n_zero  = r_zero;
        n_item  = r_item;
        n_ci    = r_ci;
        n_ei    = r_ei;
        n_k     = r_k;
        n_hit   = r_hit;
        n_hidx  = r_hidx;
        n_ov    = r_ov;
        n_out   = r_out;
        w_fmt_start = 1'b0;
        w_txt_we = 1'b0;
        w_txt_wa = {r_count[IW-1:0], r_fill[CW-1:0]};
        w_txt_wd = w_ch;
        w_len_we = 1'b0;
        w_txt_ra = {r_ei, r_k[CW-1:0]};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_ci   = 4'd0;
                    unique case (i_in_data.cmd)
                        CMD_BLACK, CMD_WHITE: begin
                            if (r_black != (i_in_data.cmd == CMD_BLACK)) begin
                                n_count = '0;
                                n_fill  = '0;
                                n_len   = '0;
                                n_zero  = 1'b0;
                            end
                            n_black = (i_in_data.cmd == CMD_BLACK);
                        end
                        CMD_CHUNK: n_state = S_CHUNK;
                        default: begin
                            n_state = S_FMT;
                            w_fmt_start = 1'b1;
                        end
                    endcase
                end
            end
            S_CHUNK: begin
                if (r_count >= ECW'(MAX_ENTRIES)) begin
                    n_fill = '0;
                    n_len  = '0;
                    n_zero = 1'b0;
                    n_state = S_IDLE;
                end else if (r_ci < w_n) begin
                    if (r_fill < CNW'(ENTRY_CHARS)) begin
                        w_txt_we = 1'b1;
                        n_fill = r_fill + CNW'(1);
                        if (w_ch == 8'd0) begin
                            n_zero = 1'b1;
                        end else if (!r_zero) begin
                            n_len = r_len + CNW'(1);
                        end
                    end
                    n_ci = r_ci + 4'd1;
                end else begin
                    if (r_item.chunk_last) begin
                        w_len_we = 1'b1;
                        n_count = r_count + ECW'(1);
                        n_fill = '0;
                        n_len  = '0;
                        n_zero = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FMT: begin
                n_ei  = '0;
                n_hit = 1'b0;
                n_hidx = '0;
                n_ov  = (r_count == '0);
                if (w_fmt_done) begin
                    n_state = (r_count == '0) ? S_OUT : S_LEN;
                end
            end
            S_LEN: begin
                // Length read issued last cycle lands in r_rd_len now.
                n_state = S_RD;
                n_k = '0;
            end
            S_RD: begin
                if (r_rd_len == '0 || w_n1 > CNW'(w_text.len)) begin
                    n_state = S_CMP;
                    n_k = CNW'(ENTRY_CHARS); // marks a skipped entry
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_k == CNW'(ENTRY_CHARS) && r_elen != r_k + CNW'(1)) begin
                    n_ov = 1'b1;                      // skipped entry
                end else if (r_k >= w_n1) begin
                    n_hit = 1'b1;
                    n_hidx = r_ei;
                    n_ov = 1'b1;
                end else if (r_rd_char != w_text.chars[r_k[4:0]]) begin
                    n_ov = 1'b1;
                end else begin
                    n_k = r_k + CNW'(1);
                    w_txt_ra = {r_ei, n_k[CW-1:0]};
                    n_state = S_RD;
                end
                if (n_ov) begin
                    if (n_hit || ECW'(r_ei) + ECW'(1) >= r_count) begin
                        n_state = S_OUT;
                    end else begin
                        n_ei = r_ei + IW'(1);
                        n_ov = 1'b0;
                        n_state = S_LEN;
                    end
                end
            end
            S_OUT: begin
                n_out.matched = r_hit;
                n_out.matched_index = 7'(r_hidx);
                n_out.verdict = r_black ? !r_hit : r_hit;
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
        endcase
    end

    // r_elen holds the raw entry length so the skip marker is unambiguous.
    always_ff @(posedge i_clk) begin
        if (w_txt_we) mem_text[w_txt_wa] <= w_txt_wd;
        if (w_len_we) mem_len[r_count[IW-1:0]] <= r_len;
        r_rd_char <= mem_text[w_txt_ra];
        r_rd_len  <= mem_len[n_ei];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_black <= 1'b1;
            r_count <= '0;
            r_fill  <= '0;
            r_len   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_black <= n_black;
            r_count <= n_count;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_zero  <= n_zero;
        end
        r_item <= n_item;
        r_ci   <= n_ci;
        r_ei   <= n_ei;
        r_k    <= n_k;
        r_elen <= (r_state == S_RD) ? r_rd_len : r_elen;
        r_hit  <= n_hit;
        r_hidx <= n_hidx;
        r_ov   <= n_ov;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ECW'(MAX_ENTRIES))
        else $error("entry count overflow");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNW'(ENTRY_CHARS))
        else $error("fill overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_out)))
        else $error("result lost under stall");
    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_out.matched) |-> (r_out.matched_index == 7'd0))
        else $error("index without match");
`endif
endmodule

@@ dv/source_text_prefix_packet_filter_top_test.sv @@
// ----------------------------------------------------------------------------
// source_text_prefix_packet_filter_top_test
// Self-checking test of the source text prefix packet filter.
// ----------------------------------------------------------------------------
// A local model keeps the mode and the rule list. It forms the source text
// of every accepted packet and queues the verdict that the block must give.
// Directed tasks cover the corner cases of entries, modes and a full list.
// A random phase then sends rule lists built from prefixes of real source
// texts, packets from the same address pool, and some noise. Both sides idle
// and stall at random, and every output transfer is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_text_prefix_packet_filter_top_test;
    import stpf_pkg::*;

    localparam int NumRules   = MaxEntriesDefault;
    localparam int RuleChars  = EntryCharsDefault;
    localparam int IdleLimit  = 20000;
    localparam int TotalItems = 550;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    source_text_prefix_packet_filter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Local copy of the filter state.
    logic           black_mode;
    int             rule_count;
    int             fill_pos;
    logic [7:0]     rule_text [NumRules][RuleChars];
    int             rule_len [NumRules];

    t_out_item      verdict_q [$];
    int             mismatch_count;
    int             items_sent;
    int             idle_cycles;
    bit             no_idle;
    logic [31:0]    addr_pool [8];
    logic [15:0]    port_pool [4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void select_mode(logic black);
        if (black_mode != black) begin
            rule_count = 0;
            fill_pos   = 0;
        end
        black_mode = black;
    endfunction

    function automatic void store_chunk(t_in_item it);
        int n;
        int len;
        n = (it.chunk_count > 8) ? 8 : int'(it.chunk_count);
        if (rule_count >= NumRules) begin
            fill_pos = 0;
            return;
        end
        for (int i = 0; i < n; i++) begin
            if (fill_pos < RuleChars) begin
                rule_text[rule_count][fill_pos] = it.chunk_bytes[8*i +: 8];
                fill_pos++;
            end
        end
        if (it.chunk_last) begin
            len = 0;
            while (len < fill_pos && rule_text[rule_count][len] != 8'd0) len++;
            rule_len[rule_count] = len;
            rule_count++;
            fill_pos = 0;
        end
    endfunction

    function automatic string source_text(logic [31:0] addr, logic [15:0] port,
                                          logic [7:0] proto);
        logic [15:0] p;
        p = (proto == PROTO_TCP || proto == PROTO_UDP) ? port : 16'd0;
        return $sformatf("%0d.%0d.%0d.%0d:%0d", addr[31:24], addr[23:16],
                         addr[15:8], addr[7:0], p);
    endfunction

    function automatic void filter_packet(t_in_item it);
        string     txt;
        t_out_item res;
        int        n;
        int        k;
        bit        hit;
        hit = 0;
        res = '0;
        txt = source_text(it.source_address, it.source_port, it.protocol);
        for (int i = 0; i < rule_count && !hit; i++) begin
            if (rule_len[i] == 0) continue;
            n = rule_len[i] - 1;
            if (n > txt.len()) continue;
            for (k = 0; k < n; k++) begin
                if (txt[k] != rule_text[i][k]) break;
            end
            if (k == n) begin
                hit = 1;
                res.matched_index = i[6:0];
            end
        end
        res.matched = hit;
        res.verdict = black_mode ? !hit : hit;
        verdict_q.push_back(res);
    endfunction

    function automatic void apply_item(t_in_item it);
        case (it.cmd)
            CMD_PACKET: filter_packet(it);
            CMD_BLACK:  select_mode(1'b1);
            CMD_WHITE:  select_mode(1'b0);
            default:    store_chunk(it);
        endcase
    endfunction

    // Drives one input transfer and updates the model once it is taken.
    task automatic send_item(t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd            = 2'($urandom_range(0, 3));
        it.source_address = $urandom;
        it.source_port    = 16'($urandom);
        it.protocol       = 8'($urandom);
        it.chunk_bytes    = {$urandom, $urandom};
        it.chunk_count    = 4'($urandom_range(0, 15));
        it.chunk_last     = 1'($urandom);
        return it;
    endfunction

    task automatic send_cmd(logic [1:0] cmd);
        t_in_item it;
        it     = noise_item();
        it.cmd = cmd;
        send_item(it);
    endtask

    task automatic send_packet(logic [31:0] addr, logic [15:0] port, logic [7:0] proto);
        t_in_item it;
        it                = noise_item();
        it.cmd            = CMD_PACKET;
        it.source_address = addr;
        it.source_port    = port;
        it.protocol       = proto;
        send_item(it);
    endtask

    // Splits an entry into chunks of random size; unused chunk bytes are junk.
    task automatic send_entry(string s);
        t_in_item it;
        int       pos;
        int       n;
        pos = 0;
        do begin
            it     = noise_item();
            it.cmd = CMD_CHUNK;
            n      = $urandom_range(1, 8);
            if (n > s.len() - pos) n = s.len() - pos;
            for (int i = 0; i < n; i++) it.chunk_bytes[8*i +: 8] = s[pos + i];
            pos += n;
            it.chunk_count = (n == 8 && $urandom_range(0, 3) == 0) ?
                             4'($urandom_range(9, 15)) : 4'(n);
            it.chunk_last  = (pos >= s.len());
            send_item(it);
        end while (pos < s.len());
    endtask

    function automatic logic [7:0] random_proto();
        case ($urandom_range(0, 3))
            0:       return PROTO_TCP;
            1:       return PROTO_UDP;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic string pool_prefix();
        string txt;
        txt = source_text(addr_pool[$urandom_range(0, 7)],
                          port_pool[$urandom_range(0, 3)], random_proto());
        return {txt.substr(0, $urandom_range(0, txt.len()) - 1), "\n"};
    endfunction

    task automatic pool_packet();
        send_packet(addr_pool[$urandom_range(0, 7)], port_pool[$urandom_range(0, 3)],
                    random_proto());
    endtask

    task automatic test_modes_and_extremes();
        send_packet(32'h0000_0000, 16'h0000, 8'h00);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP);
        send_entry("255.255.255.255:65535\n");
        send_packet(32'hFFFF_FFFF, 16'hFFFF, PROTO_UDP);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_cmd(CMD_BLACK);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP);
        send_cmd(CMD_WHITE);
        send_packet(32'hFFFF_FFFF, 16'hFFFF, PROTO_TCP);
        send_entry("10.0.0.1:0x");
        send_packet(32'h0A00_0001, 16'd80, 8'd1);
        send_packet(32'h0A00_0001, 16'd80, PROTO_TCP);
    endtask

    task automatic test_special_entries();
        t_in_item it;
        send_cmd(CMD_WHITE);
        send_entry("10.0.0.1:0");
        // A partial entry is dropped by a mode switch.
        it = noise_item();
        it.cmd = CMD_CHUNK; it.chunk_count = 4'd8; it.chunk_last = 1'b0;
        send_item(it);
        send_cmd(CMD_BLACK);
        send_packet(32'h0A00_0001, 16'd0, 8'd1);
        // Entry cut short by a zero character.
        it = noise_item();
        it.cmd = CMD_CHUNK; it.chunk_bytes = 64'h1111_0000_2E30_3231;
        it.chunk_count = 4'd8; it.chunk_last = 1'b1;
        send_item(it);
        // Empty entry by count zero.
        it = noise_item();
        it.cmd = CMD_CHUNK; it.chunk_count = 4'd0; it.chunk_last = 1'b1;
        send_item(it);
        send_entry("1.2.3.4:5678901234567890123456789\n");
        send_entry("1.2.3.4:5\n\n");
        send_packet(32'h0102_0304, 16'd5, PROTO_UDP);
        send_packet(32'h0C00_0000, 16'd0, 8'd0);
        send_entry("\n");
        send_packet(32'h0102_0304, 16'd9, PROTO_TCP);
    endtask

    task automatic test_full_list();
        send_cmd(CMD_WHITE);
        send_cmd(CMD_BLACK);
        for (int i = 0; i < NumRules + 4; i++) send_entry(pool_prefix());
        repeat (6) pool_packet();
    endtask

    task automatic test_random_traffic();
        int pick;
        while (items_sent < TotalItems) begin
            // Alternate stretches without idling on either side.
            no_idle = ($urandom_range(0, 4) == 0);
            send_cmd($urandom_range(0, 1) ? CMD_BLACK : CMD_WHITE);
            repeat ($urandom_range(0, 10)) begin
                send_entry(pool_prefix());
            end
            repeat ($urandom_range(4, 20)) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) pool_packet();
                else if (pick < 9) send_item(noise_item());
                else send_packet($urandom, 16'($urandom), 8'($urandom));
            end
        end
        no_idle = 0;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $realtime, o_out_data);
                mismatch_count++;
            end else begin
                exp = verdict_q.pop_front();
                if (o_out_data.verdict !== exp.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $realtime, exp.verdict, o_out_data.verdict);
                    mismatch_count++;
                end
                if (o_out_data.matched !== exp.matched) begin
                    $display("%0t: matched expected %0d actual %0d",
                             $realtime, exp.matched, o_out_data.matched);
                    mismatch_count++;
                end
                if (o_out_data.matched_index !== exp.matched_index) begin
                    $display("%0t: matched_index expected %0d actual %0d",
                             $realtime, exp.matched_index, o_out_data.matched_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: a random stall before every result, none while idling is off.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        mismatch_count = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        no_idle        = 0;
        black_mode     = 1'b1;
        rule_count     = 0;
        fill_pos       = 0;
        for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0A00_0001;
        for (int i = 0; i < 4; i++) port_pool[i] = 16'($urandom_range(0, 65535));
        port_pool[0] = 16'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_modes_and_extremes();
        test_special_entries();
        test_full_list();
        test_random_traffic();
        i_in_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/stpf_pkg.sv
sv/stpf_fmt.sv
sv/source_text_prefix_packet_filter_top.sv
dv/source_text_prefix_packet_filter_top_test.sv
